// ===== design/der_sig_pkg.sv =====
// package for the lax der ecdsa signature parser
// holds parse phase, status codes, frame type and the group order; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package der_sig_pkg;

    localparam int LEN_W = 16;

    typedef enum logic [3:0] {
        PH_SEQ_TAG   = 4'd0,
        PH_SEQ_LEN   = 4'd1,
        PH_SEQ_SKIP  = 4'd2,
        PH_R_TAG     = 4'd3,
        PH_R_LEN     = 4'd4,
        PH_R_LZERO   = 4'd5,
        PH_R_LBYTES  = 4'd6,
        PH_R_VAL     = 4'd7,
        PH_S_TAG     = 4'd8,
        PH_S_LEN     = 4'd9,
        PH_S_LZERO   = 4'd10,
        PH_S_LBYTES  = 4'd11,
        PH_S_VAL     = 4'd12,
        PH_DONE      = 4'd13,
        PH_FAIL      = 4'd14
    } parse_phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } parse_status_t;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_CHECK = 2'd1,
        B_EMIT  = 2'd2
    } back_state_t;

    // parsed signature handed from front to back
    typedef struct packed {
        logic [255:0]  r;
        logic [255:0]  s;
        parse_status_t pre_status;
    } frame_t;

    localparam logic [7:0] TAG_SEQ = 8'h30;
    localparam logic [7:0] TAG_INT = 8'h02;

    localparam logic [255:0] GROUP_ORDER =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;

endpackage
`default_nettype wire

// ===== design/der_sig_front.sv =====
// front part: accepts der bytes, walks the lax grammar, builds r and s
// depends on der_sig_pkg
`timescale 1ns / 1ps
`default_nettype none
module der_sig_front #(
    parameter int MAX_INPUT_BYTES = 65535
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    input  wire logic [7:0]         byte_data,
    input  wire logic               byte_last,
    output der_sig_pkg::frame_t     push_frame,
    output logic                    push
);
    import der_sig_pkg::*;

    localparam int PW = $clog2(MAX_INPUT_BYTES + 1);
    localparam int VW = (PW > 7) ? PW : 7;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_INPUT_BYTES);
    localparam logic [PW-1:0]    MAX_POS = PW'(MAX_INPUT_BYTES);

    parse_phase_t   phase_reg, phase_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [2:0]     lbl_reg, lbl_next;
    logic [LEN_W-1:0] vlen_reg, vlen_next;
    logic [VW-1:0]  vbl_reg, vbl_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic [255:0]   r_reg, r_next, s_reg, s_next;
    logic           mal_reg, mal_next, ovf_reg, ovf_next;

    // finish a length: zero skips the value, too large fails
    function automatic void do_finish(input logic is_s, input logic [LEN_W-1:0] len,
                                      inout parse_phase_t ph, inout logic mal,
                                      inout logic [VW-1:0] vbl, inout logic [5:0] cnt);
        if (len > MAX_LEN) begin
            mal = 1'b1;
            ph  = PH_FAIL;
        end else if (len == '0) begin
            ph = is_s ? PH_DONE : PH_S_TAG;
        end else begin
            vbl = VW'(len);
            cnt = '0;
            ph  = is_s ? PH_S_VAL : PH_R_VAL;
        end
    endfunction

    // next state for one accepted byte
    always_comb
    begin
        logic       is_s;
        logic [2:0] off;
        logic [VW-1:0] vbl_dec;
        logic [255:0] dst;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        lbl_next   = lbl_reg;
        vlen_next  = vlen_reg;
        vbl_next   = vbl_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        mal_next   = mal_reg;
        ovf_next   = ovf_reg;
        is_s       = (phase_reg >= PH_S_TAG);
        off        = is_s ? 3'(phase_reg - PH_S_TAG) : 3'(phase_reg - PH_R_TAG);
        vbl_dec    = vbl_reg - VW'(1);
        dst        = is_s ? s_reg : r_reg;
        if (byte_valid) begin
            if (pos_reg >= MAX_POS) begin
                mal_next   = 1'b1;
                phase_next = PH_FAIL;
            end else begin
                pos_next = pos_reg + PW'(1);
                case (phase_reg)
                    PH_SEQ_TAG:
                    begin
                        if (byte_data != TAG_SEQ) begin
                            mal_next   = 1'b1;
                            phase_next = PH_FAIL;
                        end else begin
                            phase_next = PH_SEQ_LEN;
                        end
                    end
                    PH_SEQ_LEN:
                    begin
                        if (byte_data[7] && byte_data[6:0] != 7'd0) begin
                            vbl_next   = VW'(byte_data[6:0]);
                            phase_next = PH_SEQ_SKIP;
                        end else begin
                            phase_next = PH_R_TAG;
                        end
                    end
                    PH_SEQ_SKIP:
                    begin
                        vbl_next = vbl_dec;
                        if (vbl_dec == '0)
                            phase_next = PH_R_TAG;
                    end
                    PH_DONE, PH_FAIL:
                    begin
                    end
                    default:
                    begin
                        case (off)
                            3'd0:
                            begin
                                if (byte_data != TAG_INT) begin
                                    mal_next   = 1'b1;
                                    phase_next = PH_FAIL;
                                end else begin
                                    phase_next = parse_phase_t'(phase_reg + 4'd1);
                                end
                            end
                            3'd1:
                            begin
                                if (!byte_data[7])
                                    do_finish(is_s, LEN_W'(byte_data), phase_next,
                                              mal_next, vbl_next, cnt_next);
                                else if (byte_data[6:0] == 7'd0)
                                    do_finish(is_s, '0, phase_next, mal_next,
                                              vbl_next, cnt_next);
                                else begin
                                    vbl_next   = VW'(byte_data[6:0]);
                                    phase_next = parse_phase_t'(phase_reg + 4'd1);
                                end
                            end
                            3'd2:
                            begin
                                if (byte_data == 8'd0) begin
                                    vbl_next = vbl_dec;
                                    if (vbl_dec == '0)
                                        do_finish(is_s, '0, phase_next, mal_next,
                                                  vbl_next, cnt_next);
                                end else if (vbl_reg >= VW'(8)) begin
                                    mal_next   = 1'b1;
                                    phase_next = PH_FAIL;
                                end else begin
                                    lbl_next  = vbl_dec[2:0];
                                    vlen_next = LEN_W'(byte_data);
                                    if (vbl_dec[2:0] == 3'd0)
                                        do_finish(is_s, LEN_W'(byte_data), phase_next,
                                                  mal_next, vbl_next, cnt_next);
                                    else
                                        phase_next = parse_phase_t'(phase_reg + 4'd1);
                                end
                            end
                            3'd3:
                            begin
                                if (vlen_reg > LEN_W'(8'hFF)) begin
                                    mal_next   = 1'b1;
                                    phase_next = PH_FAIL;
                                end else begin
                                    vlen_next = {vlen_reg[LEN_W-9:0], byte_data};
                                    lbl_next  = lbl_reg - 3'd1;
                                    if (lbl_reg == 3'd1)
                                        do_finish(is_s, {vlen_reg[LEN_W-9:0], byte_data},
                                                  phase_next, mal_next, vbl_next,
                                                  cnt_next);
                                end
                            end
                            3'd4:
                            begin
                                // value byte: strip leading zeros, shift in the rest
                                if (!(cnt_reg == 6'd0 && byte_data == 8'd0)) begin
                                    if (cnt_reg >= 6'd32) begin
                                        cnt_next = 6'd33;
                                        ovf_next = 1'b1;
                                    end else begin
                                        cnt_next = cnt_reg + 6'd1;
                                        dst      = {dst[247:0], byte_data};
                                    end
                                end
                                if (is_s)
                                    s_next = dst;
                                else
                                    r_next = dst;
                                vbl_next = vbl_dec;
                                if (vbl_dec == '0)
                                    phase_next = is_s ? PH_DONE : PH_S_TAG;
                            end
                            default:
                            begin
                                mal_next   = 1'b1;
                                phase_next = PH_FAIL;
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    // frame for the queue, built from the state after the last byte
    always_comb
    begin
        push_frame.r = r_next;
        push_frame.s = s_next;
        if (mal_next || phase_next != PH_DONE)
            push_frame.pre_status = ST_MALFORMED;
        else if (ovf_next)
            push_frame.pre_status = ST_OVERFLOW;
        else
            push_frame.pre_status = ST_OK;
        push = byte_valid && byte_last;
    end

    // parser state, cleared after each signature
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_SEQ_TAG;
            pos_reg   <= '0;
            lbl_reg   <= '0;
            vlen_reg  <= '0;
            vbl_reg   <= '0;
            cnt_reg   <= '0;
            r_reg     <= '0;
            s_reg     <= '0;
            mal_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end else if (byte_valid && byte_last) begin
            phase_reg <= PH_SEQ_TAG;
            pos_reg   <= '0;
            lbl_reg   <= '0;
            vlen_reg  <= '0;
            vbl_reg   <= '0;
            cnt_reg   <= '0;
            r_reg     <= '0;
            s_reg     <= '0;
            mal_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            lbl_reg   <= lbl_next;
            vlen_reg  <= vlen_next;
            vbl_reg   <= vbl_next;
            cnt_reg   <= cnt_next;
            r_reg     <= r_next;
            s_reg     <= s_next;
            mal_reg   <= mal_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/der_sig_queue.sv =====
// two-entry frame queue between front and back
// depends on der_sig_pkg
`timescale 1ns / 1ps
`default_nettype none
module der_sig_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire der_sig_pkg::frame_t push_frame,
    output logic                     full,
    input  wire logic                pop,
    output logic                     not_empty,
    output der_sig_pkg::frame_t      head
);
    import der_sig_pkg::*;

    frame_t     mem [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_reg] <= push_frame;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push && !full)
                wr_reg <= !wr_reg;
            if (pop && not_empty)
                rd_reg <= !rd_reg;
            count_reg <= count_reg + 2'(push && !full) - 2'(pop && not_empty);
        end
    end

endmodule
`default_nettype wire

// ===== design/der_sig_back.sv =====
// back part: checks r and s against the group order and sends eight words
// depends on der_sig_pkg
`timescale 1ns / 1ps
`default_nettype none
module der_sig_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                not_empty,
    input  wire der_sig_pkg::frame_t head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [63:0]              sig_word,
    output logic [2:0]               word_index,
    output logic [1:0]               parse_status,
    output logic                     out_last
);
    import der_sig_pkg::*;

    back_state_t   state_reg, state_next;
    logic [511:0]  rs_reg;
    parse_status_t pre_reg, status_reg;
    logic [2:0]    idx_reg;
    logic          done_word;

    assign done_word = out_valid && out_ready && (idx_reg == 3'd7);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (not_empty)
                    state_next = B_CHECK;
            B_CHECK:
                state_next = B_EMIT;
            B_EMIT:
                if (done_word)
                    state_next = not_empty ? B_CHECK : B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop          = not_empty && ((state_reg == B_IDLE) || done_word);
        out_valid    = (state_reg == B_EMIT);
        word_index   = idx_reg;
        parse_status = status_reg;
        out_last     = (idx_reg == 3'd7);
        sig_word     = (status_reg == ST_OK) ? rs_reg[511 - 64 * idx_reg -: 64] : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= B_IDLE;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CHECK)
                idx_reg <= 3'd0;
            else if (out_valid && out_ready)
                idx_reg <= idx_reg + 3'd1;
        end
    end

    // frame load and order check
    always_ff @(posedge clk)
    begin
        if (pop) begin
            rs_reg  <= {head.r, head.s};
            pre_reg <= head.pre_status;
        end
        if (state_reg == B_CHECK) begin
            if (pre_reg != ST_OK)
                status_reg <= pre_reg;
            else if (rs_reg[511:256] >= GROUP_ORDER || rs_reg[255:0] >= GROUP_ORDER)
                status_reg <= ST_OVERFLOW;
            else
                status_reg <= ST_OK;
        end
    end

endmodule
`default_nettype wire

// ===== design/der_ecdsa_signature_lax_parser_core.sv =====
// lax der ecdsa signature parser: one byte per cycle in while s_tready, eight 64-bit words out
// the last byte's frame passes the queue and the check state before the first word
// throughput: one byte per cycle unless the queue is full; per signature a check state, then 8 words
// a two-frame queue lets the parser run on while words are sent
// reset (rst_n low, asynchronous) returns parser, queue and sender to idle
`timescale 1ns / 1ps
`default_nettype none
module der_ecdsa_signature_lax_parser_core #(
    parameter int MAX_INPUT_BYTES = 65535
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // sig_word[63:0], word_index[66:64], parse_status[68:67]
    output logic             m_tlast
);
    import der_sig_pkg::*;

    frame_t      push_frame, head;
    logic        push, full, pop, not_empty;
    logic [63:0] sig_word;
    logic [2:0]  word_index;
    logic [1:0]  parse_status;

    assign s_tready = !full;

    der_sig_front #(
        .MAX_INPUT_BYTES(MAX_INPUT_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid && s_tready),
        .byte_data  (s_tdata),
        .byte_last  (s_tlast),
        .push_frame (push_frame),
        .push       (push)
    );

    der_sig_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    der_sig_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .sig_word     (sig_word),
        .word_index   (word_index),
        .parse_status (parse_status),
        .out_last     (m_tlast)
    );

    assign m_tdata = {3'd0, parse_status, word_index, sig_word};

endmodule
`default_nettype wire

// ===== design/der_sig_checker.sv =====
// port checker for the signature parser, bound to the top level
// depends on the top level's ports and der_sig_pkg
`timescale 1ns / 1ps
`default_nettype none
module der_sig_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tlast
);
    import der_sig_pkg::*;

    // words are zero unless status is ok
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[68:67] != ST_OK |-> m_tdata[63:0] == 64'd0)
        else $error("nonzero word with error status");

    // last marks the eighth word only
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[66:64] == 3'd7)))
        else $error("tlast does not match word index");

    // status code is always defined
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[68:67] == ST_OK || m_tdata[68:67] == ST_MALFORMED ||
                      m_tdata[68:67] == ST_OVERFLOW))
        else $error("undefined status code");

    // word index advances by one inside a signature
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
            m_tdata[66:64] == $past(m_tdata[66:64]) + 3'd1)
        else $error("word index skipped");
endmodule

bind der_ecdsa_signature_lax_parser_core der_sig_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== sim/tb_der_ecdsa_signature_lax_parser_core.sv =====
// testbench for the lax der ecdsa signature parser core
// depends on der_sig_pkg and der_ecdsa_signature_lax_parser_core
`timescale 1ns / 1ps
module tb_der_ecdsa_signature_lax_parser_core;
    import der_sig_pkg::*;

    localparam int MAX_BYTES = 65535;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } sig_byte_t;

    typedef struct packed {
        logic [63:0]   word;
        logic [2:0]    index;
        parse_status_t status;
        logic          last;
    } sig_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    sig_byte_t pending_bytes[$];
    sig_word_t expected_words[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        failed = 1'b0;
    bit        in_taken = 1'b0;
    int        quiet_cycles = 0;
    logic [7:0] sig_buf[$];

    // parser shadow state
    parse_phase_t ph;
    int        pos;
    int        len_left;
    int        val_len;
    int        val_left;
    int        sig_count;
    logic [255:0] r_val;
    logic [255:0] s_val;
    bit        bad;
    bit        ovf;

    der_ecdsa_signature_lax_parser_core dut (.*);

    always #5 clk = ~clk;

    function automatic void clear_parser();
        ph = PH_SEQ_TAG;
        pos = 0;
        len_left = 0;
        val_len = 0;
        val_left = 0;
        sig_count = 0;
        r_val = '0;
        s_val = '0;
        bad = 1'b0;
        ovf = 1'b0;
    endfunction

    function automatic void parse_fail();
        bad = 1'b1;
        ph = PH_FAIL;
    endfunction

    function automatic void end_length(bit is_s, int len);
        if (len > MAX_BYTES)
            parse_fail();
        else if (len == 0)
            ph = is_s ? PH_DONE : PH_S_TAG;
        else begin
            val_left = len;
            sig_count = 0;
            ph = is_s ? PH_S_VAL : PH_R_VAL;
        end
    endfunction

    // one byte through the integer sub-parser (r or s)
    function automatic void integer_step(bit is_s, logic [7:0] b);
        parse_phase_t base;
        int off;
        base = is_s ? PH_S_TAG : PH_R_TAG;
        off = int'(ph) - int'(base);
        case (off)
            0: if (b != TAG_INT) parse_fail(); else ph = parse_phase_t'(base + 1);
            1: begin
                if (!b[7]) end_length(is_s, b);
                else if (b[6:0] == 0) end_length(is_s, 0);
                else begin
                    val_left = b[6:0];
                    ph = parse_phase_t'(base + 2);
                end
            end
            2: begin
                if (b == 0) begin
                    val_left--;
                    if (val_left == 0) end_length(is_s, 0);
                end else if (val_left >= 8) parse_fail();
                else begin
                    len_left = val_left - 1;
                    val_len = b;
                    if (len_left == 0) end_length(is_s, val_len);
                    else ph = parse_phase_t'(base + 3);
                end
            end
            3: begin
                if (val_len > 255) parse_fail();
                else begin
                    val_len = (val_len << 8) | b;
                    len_left--;
                    if (len_left == 0) end_length(is_s, val_len);
                end
            end
            default: begin
                if (!(sig_count == 0 && b == 0)) begin
                    if (sig_count < 33) sig_count++;
                    if (sig_count > 32) ovf = 1'b1;
                    else if (is_s) s_val = {s_val[247:0], b};
                    else r_val = {r_val[247:0], b};
                end
                val_left--;
                if (val_left == 0) ph = is_s ? PH_DONE : PH_S_TAG;
            end
        endcase
    endfunction

    // advance the shadow parser by one accepted byte, queue words on last
    function automatic void predict_signature_byte(logic [7:0] b, logic last);
        parse_status_t st;
        logic [511:0] both;
        sig_word_t w;
        if (pos >= MAX_BYTES) parse_fail();
        else pos++;
        case (ph)
            PH_SEQ_TAG: if (b != TAG_SEQ) parse_fail(); else ph = PH_SEQ_LEN;
            PH_SEQ_LEN: begin
                if (b[7] && b[6:0] != 0) begin
                    val_left = b[6:0];
                    ph = PH_SEQ_SKIP;
                end else ph = PH_R_TAG;
            end
            PH_SEQ_SKIP: begin
                val_left--;
                if (val_left == 0) ph = PH_R_TAG;
            end
            PH_DONE, PH_FAIL: ;
            default: begin
                if (ph < PH_S_TAG) integer_step(1'b0, b);
                else integer_step(1'b1, b);
            end
        endcase
        if (!last) return;
        if (bad || ph != PH_DONE) st = ST_MALFORMED;
        else if (ovf || r_val >= GROUP_ORDER || s_val >= GROUP_ORDER) st = ST_OVERFLOW;
        else st = ST_OK;
        both = {r_val, s_val};
        for (int k = 0; k < 8; k++) begin
            w.word = (st == ST_OK) ? both[511 - 64 * k -: 64] : 64'd0;
            w.index = k[2:0];
            w.status = st;
            w.last = (k == 7);
            expected_words.push_back(w);
        end
        clear_parser();
    endfunction

    // bytes of a value of n random bytes with a chosen first byte
    function automatic void push_value(int n, int first);
        for (int i = 0; i < n; i++)
            sig_buf.push_back(i == 0 && first >= 0 ? first[7:0] : 8'($urandom));
    endfunction

    function automatic void push_length(int n, bit long_form, int zeros);
        if (!long_form && n < 128) sig_buf.push_back(n[7:0]);
        else if (n < 256) begin
            sig_buf.push_back(8'h81 + zeros[7:0]);
            repeat (zeros) sig_buf.push_back(8'h00);
            sig_buf.push_back(n[7:0]);
        end else begin
            sig_buf.push_back(8'h82 + zeros[7:0]);
            repeat (zeros) sig_buf.push_back(8'h00);
            sig_buf.push_back(n[15:8]);
            sig_buf.push_back(n[7:0]);
        end
    endfunction

    function automatic void push_integer(int n, int first);
        sig_buf.push_back(TAG_INT);
        push_length(n, $urandom_range(0, 3) == 0, $urandom_range(0, 2));
        push_value(n, first);
    endfunction

    // send the buffered signature, last flag on its final byte
    function automatic void flush_signature();
        sig_byte_t it;
        foreach (sig_buf[i]) begin
            it.data = sig_buf[i];
            it.last = (i == sig_buf.size() - 1);
            pending_bytes.push_back(it);
        end
        sig_buf.delete();
    endfunction

    // random well-formed signature, sometimes with damage
    function automatic void random_signature();
        int rlen, slen;
        int mode;
        rlen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 34) : $urandom_range(30, 33);
        slen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 34) : $urandom_range(30, 33);
        mode = $urandom_range(0, 9);
        sig_buf.push_back(mode == 0 ? 8'($urandom) : TAG_SEQ);
        if ($urandom_range(0, 3) == 0) begin
            sig_buf.push_back(8'h82);
            sig_buf.push_back(8'($urandom));
            sig_buf.push_back(8'($urandom));
        end else sig_buf.push_back($urandom_range(0, 1) ? 8'h80 : 8'($urandom_range(0, 127)));
        push_integer(rlen, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 255));
        if (mode == 1) sig_buf[sig_buf.size() - 1] = TAG_SEQ;
        push_integer(slen, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 127));
        if (mode == 2) repeat ($urandom_range(1, 4)) sig_buf.push_back(8'($urandom));
        if (mode == 3) repeat ($urandom_range(1, 6)) void'(sig_buf.pop_back());
        if (mode == 4) sig_buf[$urandom_range(0, sig_buf.size() - 1)] = 8'($urandom);
        if (sig_buf.size() == 0) sig_buf.push_back(TAG_SEQ);
        flush_signature();
    endfunction

    // driver: presents bytes at the falling edge
    always @(negedge clk) begin
        if (rst_n) begin
            // drop the byte taken at the last rising edge
            if (in_taken) begin
                void'(pending_bytes.pop_front());
            end
            if (s_tvalid && !in_taken) begin
                // hold until accepted
            end else if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_bytes[0].data;
                s_tlast <= pending_bytes[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: checks words and feeds the predictor at the rising edge
    always @(posedge clk) begin
        sig_word_t got, exp_w;
        if (rst_n) begin
            in_taken = s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (s_tvalid && s_tready) begin
                predict_signature_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                got.word = m_tdata[63:0];
                got.index = m_tdata[66:64];
                got.status = parse_status_t'(m_tdata[68:67]);
                got.last = m_tlast;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    failed = 1'b1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got.word !== exp_w.word)
                        $display("%0t: sig_word expected %h actual %h", $time,
                                 exp_w.word, got.word);
                    if (got.index !== exp_w.index)
                        $display("%0t: word_index expected %0d actual %0d", $time,
                                 exp_w.index, got.index);
                    if (got.status !== exp_w.status)
                        $display("%0t: parse_status expected %0d actual %0d", $time,
                                 exp_w.status, got.status);
                    if (got.last !== exp_w.last)
                        $display("%0t: out_last expected %0b actual %0b", $time,
                                 exp_w.last, got.last);
                    if (got !== exp_w) failed = 1'b1;
                end
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: minimal, zero values, maximal in-range values
        sig_buf = '{TAG_SEQ, 8'h04, TAG_INT, 8'h00, TAG_INT, 8'h00};
        flush_signature();
        sig_buf = '{TAG_SEQ, 8'h80, TAG_INT, 8'h80, TAG_INT, 8'h83, 8'h00, 8'h00, 8'h00};
        flush_signature();
        // r = order - 1, s = order (overflow)
        sig_buf.push_back(TAG_SEQ); sig_buf.push_back(8'h44);
        sig_buf.push_back(TAG_INT); sig_buf.push_back(8'h21); sig_buf.push_back(8'h00);
        for (int i = 0; i < 32; i++)
            sig_buf.push_back(8'(GROUP_ORDER[255 - 8 * i -: 8] - 8'(i == 31)));
        sig_buf.push_back(TAG_INT); sig_buf.push_back(8'h20);
        for (int i = 0; i < 32; i++) sig_buf.push_back(GROUP_ORDER[255 - 8 * i -: 8]);
        flush_signature();
        // wrong tag, early end, huge length, too many length bytes, short value, trailing byte, 33 significant bytes
        sig_buf = '{8'hFF, 8'h02, 8'h00};
        flush_signature();
        sig_buf = '{TAG_SEQ, 8'h85, 8'h01, 8'h02};
        flush_signature();
        sig_buf = '{TAG_SEQ, 8'h06, TAG_INT, 8'h83, 8'h01, 8'h00, 8'h00, TAG_INT, 8'h00};
        flush_signature();
        sig_buf = '{TAG_SEQ, 8'h06, TAG_INT, 8'h88, 8'h01, 8'h00};
        flush_signature();
        sig_buf = '{TAG_SEQ, 8'h06, TAG_INT, 8'h82, 8'h01, 8'h10, 8'h00};
        flush_signature();
        sig_buf = '{TAG_SEQ, 8'h06, TAG_INT, 8'h01, 8'h01, 8'h02, 8'h00, 8'h55, 8'hAA};
        flush_signature();
        sig_buf = '{TAG_SEQ, 8'h00, TAG_INT, 8'h21};
        push_value(33, 1);
        sig_buf.push_back(TAG_INT); sig_buf.push_back(8'h01); sig_buf.push_back(8'h01);
        flush_signature();
        while (pending_bytes.size() > 0 || expected_words.size() > 0) @(posedge clk);

        // random phases with differing idling
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = (p == 1 || p == 3) ? (p == 3 ? 25 : 51) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? (p == 3 ? 25 : 51) : 0;
            random_signature();
            while (pending_bytes.size() > 0 || expected_words.size() > 0) @(posedge clk);
        end

        repeat (20) @(posedge clk);
        if (!failed && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/der_sig_pkg.sv
design/der_sig_front.sv
design/der_sig_queue.sv
design/der_sig_back.sv
design/der_ecdsa_signature_lax_parser_core.sv
design/der_sig_checker.sv
sim/tb_der_ecdsa_signature_lax_parser_core.sv
